[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define TWSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs across reset.
`define TWSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/twsc_pkg.sv]
// Shared types, constants and helper functions of the text word statistics block.
package twsc_pkg;

   localparam int CountBits = 20;
   localparam int WordBytes = 49;
   localparam int Chunks    = 7;
   localparam int TopCount  = 5;

   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_TEXT  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_LETTER = 2'd1;
   localparam logic [1:0] OP_OTHER  = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   localparam logic ITEM_SUMMARY = 1'b0;
   localparam logic ITEM_WORD    = 1'b1;

   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic       is_space;
      logic       is_mark;
   } op_type;

   typedef struct packed {
      logic [5:0] len;
      count_type  cnt;
   } meta_type;

   typedef struct packed {
      logic       item_kind;
      count_type  letter_total;
      count_type  space_total;
      count_type  word_total;
      count_type  sentence_total;
      count_type  match_total;
      logic [2:0] rank;
      count_type  frequency;
      logic [63:0] text_chunk;
      logic [2:0] chunk_index;
      logic [5:0] word_length;
      logic       last;
   } rsp_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == {CountBits{1'b1}}) ? v : v + count_type'(1);
   endfunction

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [63:0] lower_chunk(input logic [63:0] v);
      logic [63:0] r;
      for (int b = 0; b < 8; b++) begin
         r[b*8 +: 8] = lower_byte(v[b*8 +: 8]);
      end
      return r;
   endfunction

   // Keep the bytes of chunk k that lie below len.
   function automatic logic [63:0] chunk_mask(input logic [2:0] k, input logic [5:0] len);
      logic [63:0] m;
      for (int b = 0; b < 8; b++) begin
         m[b*8 +: 8] = ({k, 3'b000} + 6'(b) < len) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

[hdl/twsc_front.sv]
// Front end: accepts requests, classifies them and queues the operations.
module twsc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_byte,
   input  logic             op_pop,
   output logic             op_valid,
   output twsc_pkg::op_type op_head
);

   localparam int Depth = 4;

   twsc_pkg::op_type queue_ff [Depth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;
   twsc_pkg::op_type op_new;
   logic push, alpha;

   assign req_ready = (fill_ff != 3'(Depth));
   assign op_valid  = (fill_ff != 3'd0);
   assign op_head   = queue_ff[rd_ptr_ff];

   always_comb begin
      alpha = (req_byte >= 8'h41 && req_byte <= 8'h5a) ||
              (req_byte >= 8'h61 && req_byte <= 8'h7a);
      op_new.ch       = twsc_pkg::lower_byte(req_byte);
      op_new.is_space = (req_byte >= 8'd9 && req_byte <= 8'd13) || req_byte == 8'd32;
      op_new.is_mark  = req_byte == 8'h2e || req_byte == 8'h21 || req_byte == 8'h3f;
      push = req_valid && req_ready;
      case (req_cmd)
         twsc_pkg::CMD_BEGIN: op_new.kind = twsc_pkg::OP_BEGIN;
         twsc_pkg::CMD_TEXT:  op_new.kind = alpha ? twsc_pkg::OP_LETTER : twsc_pkg::OP_OTHER;
         twsc_pkg::CMD_END:   op_new.kind = twsc_pkg::OP_END;
         default: begin
            // drop the unused command
            op_new.kind = twsc_pkg::OP_BEGIN;
            push = 1'b0;
         end
      endcase
      wr_ptr_in = wr_ptr_ff + (push ? 2'd1 : 2'd0);
      rd_ptr_in = rd_ptr_ff + (op_pop ? 2'd1 : 2'd0);
      fill_in   = fill_ff + (push ? 3'd1 : 3'd0) - (op_pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         fill_ff   <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

[hdl/twsc_back.sv]
// Back end: counters, word table search and insert, ranking and result output.
module twsc_back #(
   parameter int MAX_DISTINCT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  twsc_pkg::op_type    op_head,
   output logic                op_pop,
   input  logic [6:0][63:0]    target,
   input  logic [5:0]          target_len,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output twsc_pkg::rsp_type   rsp_data
);

   localparam int IdxW  = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
   localparam int NumW  = $clog2(MAX_DISTINCT + 1);
   localparam int AddrW = IdxW + 3;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_MATCH    = 5'd1;
   localparam logic [4:0] S_SRCH     = 5'd2;
   localparam logic [4:0] S_SRCH_CHK = 5'd3;
   localparam logic [4:0] S_SRCH_CMP = 5'd4;
   localparam logic [4:0] S_INSERT   = 5'd5;
   localparam logic [4:0] S_INS_C    = 5'd6;
   localparam logic [4:0] S_SUM      = 5'd7;
   localparam logic [4:0] S_RNK      = 5'd8;
   localparam logic [4:0] S_SCAN     = 5'd9;
   localparam logic [4:0] S_SCAN_CHK = 5'd10;
   localparam logic [4:0] S_SWAP     = 5'd11;
   localparam logic [4:0] S_SW_M2    = 5'd12;
   localparam logic [4:0] S_SW_RA    = 5'd13;
   localparam logic [4:0] S_SW_RB    = 5'd14;
   localparam logic [4:0] S_SW_WA    = 5'd15;
   localparam logic [4:0] S_SW_WB    = 5'd16;
   localparam logic [4:0] S_EMIT_RD  = 5'd17;
   localparam logic [4:0] S_EMIT     = 5'd18;

   logic [4:0] state_ff, state_in;
   twsc_pkg::count_type letter_ff, letter_in, space_ff, space_in, word_ff, word_in;
   twsc_pkg::count_type sent_ff, sent_in, match_ff, match_in;
   logic [5:0] plen_ff, plen_in;
   logic [twsc_pkg::Chunks*64-1:0] pend_ff, pend_in;
   logic [NumW-1:0] distinct_ff, distinct_in, j_ff, j_in;
   logic [2:0] k_ff, k_in, i_ff, i_in, ranks_ff, ranks_in;
   logic [IdxW-1:0] best_ff, best_in;
   twsc_pkg::meta_type best_meta_ff, best_meta_in, imeta_ff, imeta_in;
   logic match_ok_ff, match_ok_in, end_ff, end_in;
   logic [63:0] tmp_ff, tmp_in;
   twsc_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   twsc_pkg::meta_type meta_mem [MAX_DISTINCT];
   logic [63:0] chunk_mem [MAX_DISTINCT*8];
   twsc_pkg::meta_type meta_q, meta_wdata;
   logic [63:0] chunk_q, chunk_wdata;
   logic meta_we, chunk_we;
   logic [IdxW-1:0] meta_raddr, meta_waddr;
   logic [AddrW-1:0] chunk_raddr, chunk_waddr;

   logic out_free, ok;
   logic [2:0] plast, elast;
   logic [63:0] pchunk, pmask;
   logic [IdxW-1:0] j_idx, i_idx, d_idx;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      plast    = 3'((plen_ff - 6'd1) >> 3);
      elast    = 3'((best_meta_ff.len - 6'd1) >> 3);
      pmask    = twsc_pkg::chunk_mask(k_ff, plen_ff);
      pchunk   = pend_ff[k_ff*64 +: 64] & pmask;
      j_idx    = j_ff[IdxW-1:0];
      i_idx    = IdxW'(i_ff);
      d_idx    = distinct_ff[IdxW-1:0];
      ok       = match_ok_ff &&
                 ((pchunk ^ (twsc_pkg::lower_chunk(target[k_ff]) & pmask)) == 64'd0);

      state_in     = state_ff;
      letter_in    = letter_ff;
      space_in     = space_ff;
      word_in      = word_ff;
      sent_in      = sent_ff;
      match_in     = match_ff;
      plen_in      = plen_ff;
      pend_in      = pend_ff;
      distinct_in  = distinct_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      ranks_in     = ranks_ff;
      best_in      = best_ff;
      best_meta_in = best_meta_ff;
      imeta_in     = imeta_ff;
      match_ok_in  = match_ok_ff;
      end_in       = end_ff;
      tmp_in       = tmp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_pop       = 1'b0;
      meta_we      = 1'b0;
      meta_waddr   = j_idx;
      meta_wdata   = meta_q;
      meta_raddr   = j_idx;
      chunk_we     = 1'b0;
      chunk_waddr  = {j_idx, k_ff};
      chunk_wdata  = pchunk;
      chunk_raddr  = {j_idx, k_ff};

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_pop = 1'b1;
               case (op_head.kind)
                  twsc_pkg::OP_BEGIN: begin
                     letter_in   = '0;
                     space_in    = '0;
                     word_in     = '0;
                     sent_in     = '0;
                     match_in    = '0;
                     plen_in     = 6'd0;
                     distinct_in = '0;
                  end
                  twsc_pkg::OP_LETTER: begin
                     letter_in = twsc_pkg::sat_inc(letter_ff);
                     if (plen_ff < 6'(twsc_pkg::WordBytes)) begin
                        pend_in[plen_ff*8 +: 8] = op_head.ch;
                        plen_in = plen_ff + 6'd1;
                     end
                  end
                  twsc_pkg::OP_OTHER: begin
                     if (op_head.is_space) space_in = twsc_pkg::sat_inc(space_ff);
                     if (op_head.is_mark) sent_in = twsc_pkg::sat_inc(sent_ff);
                     if (plen_ff != 6'd0) begin
                        word_in     = twsc_pkg::sat_inc(word_ff);
                        match_ok_in = (target_len == plen_ff);
                        k_in        = 3'd0;
                        state_in    = S_MATCH;
                     end
                  end
                  default: begin
                     end_in = 1'b1;
                     if (plen_ff != 6'd0) begin
                        word_in     = twsc_pkg::sat_inc(word_ff);
                        match_ok_in = (target_len == plen_ff);
                        k_in        = 3'd0;
                        state_in    = S_MATCH;
                     end else begin
                        state_in = S_SUM;
                     end
                  end
               endcase
            end
         end
         S_MATCH: begin
            if (k_ff == plast) begin
               if (ok) match_in = twsc_pkg::sat_inc(match_ff);
               j_in     = '0;
               state_in = S_SRCH;
            end else begin
               match_ok_in = ok;
               k_in        = k_ff + 3'd1;
            end
         end
         S_SRCH: begin
            if (j_ff == distinct_ff) begin
               state_in = S_INSERT;
            end else begin
               state_in = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (meta_q.len == plen_ff) begin
               chunk_raddr = {j_idx, 3'd0};
               k_in        = 3'd0;
               state_in    = S_SRCH_CMP;
            end else begin
               j_in     = j_ff + NumW'(1);
               state_in = S_SRCH;
            end
         end
         S_SRCH_CMP: begin
            chunk_raddr = {j_idx, k_ff + 3'd1};
            if (chunk_q != pchunk) begin
               j_in     = j_ff + NumW'(1);
               state_in = S_SRCH;
            end else if (k_ff == plast) begin
               meta_we    = 1'b1;
               meta_wdata = '{len: meta_q.len, cnt: twsc_pkg::sat_inc(meta_q.cnt)};
               plen_in    = 6'd0;
               state_in   = end_ff ? S_SUM : S_IDLE;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_INSERT: begin
            if (32'(distinct_ff) < MAX_DISTINCT) begin
               meta_we    = 1'b1;
               meta_waddr = d_idx;
               meta_wdata = '{len: plen_ff, cnt: twsc_pkg::count_type'(1)};
               k_in       = 3'd0;
               state_in   = S_INS_C;
            end else begin
               plen_in  = 6'd0;
               state_in = end_ff ? S_SUM : S_IDLE;
            end
         end
         S_INS_C: begin
            chunk_we    = 1'b1;
            chunk_waddr = {d_idx, k_ff};
            if (k_ff == plast) begin
               distinct_in = distinct_ff + NumW'(1);
               plen_in     = 6'd0;
               state_in    = end_ff ? S_SUM : S_IDLE;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_SUM: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.item_kind      = twsc_pkg::ITEM_SUMMARY;
               rsp_in.letter_total   = letter_ff;
               rsp_in.space_total    = space_ff;
               rsp_in.word_total     = word_ff;
               rsp_in.sentence_total = sent_ff;
               rsp_in.match_total    = match_ff;
               rsp_in.last           = (distinct_ff == '0);
               ranks_in = (32'(distinct_ff) < twsc_pkg::TopCount) ?
                          3'(distinct_ff) : 3'(twsc_pkg::TopCount);
               i_in = 3'd0;
               if (distinct_ff == '0) begin
                  end_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RNK;
               end
            end
         end
         S_RNK: begin
            j_in     = NumW'(i_ff);
            best_in  = i_idx;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (j_ff == NumW'(i_ff)) begin
               imeta_in     = meta_q;
               best_meta_in = meta_q;
               best_in      = i_idx;
            end else if (meta_q.cnt > best_meta_ff.cnt) begin
               best_meta_in = meta_q;
               best_in      = j_idx;
            end
            if (j_ff + NumW'(1) == distinct_ff) begin
               state_in = S_SWAP;
            end else begin
               j_in     = j_ff + NumW'(1);
               state_in = S_SCAN;
            end
         end
         S_SWAP: begin
            k_in = 3'd0;
            if (best_ff == i_idx) begin
               state_in = S_EMIT_RD;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = i_idx;
               meta_wdata = best_meta_ff;
               state_in   = S_SW_M2;
            end
         end
         S_SW_M2: begin
            meta_we    = 1'b1;
            meta_waddr = best_ff;
            meta_wdata = imeta_ff;
            state_in   = S_SW_RA;
         end
         S_SW_RA: begin
            chunk_raddr = {i_idx, k_ff};
            state_in    = S_SW_RB;
         end
         S_SW_RB: begin
            chunk_raddr = {best_ff, k_ff};
            tmp_in      = chunk_q;
            state_in    = S_SW_WA;
         end
         S_SW_WA: begin
            chunk_we    = 1'b1;
            chunk_waddr = {i_idx, k_ff};
            chunk_wdata = chunk_q;
            state_in    = S_SW_WB;
         end
         S_SW_WB: begin
            chunk_we    = 1'b1;
            chunk_waddr = {best_ff, k_ff};
            chunk_wdata = tmp_ff;
            if (k_ff == 3'(twsc_pkg::Chunks - 1)) begin
               k_in     = 3'd0;
               state_in = S_EMIT_RD;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = S_SW_RA;
            end
         end
         S_EMIT_RD: begin
            chunk_raddr = {i_idx, k_ff};
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            chunk_raddr = {i_idx, k_ff};
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.item_kind   = twsc_pkg::ITEM_WORD;
               rsp_in.rank        = i_ff;
               rsp_in.frequency   = best_meta_ff.cnt;
               rsp_in.text_chunk  = chunk_q;
               rsp_in.chunk_index = k_ff;
               rsp_in.word_length = best_meta_ff.len;
               rsp_in.last        = (k_ff == elast) && (i_ff + 3'd1 == ranks_ff);
               if (k_ff == elast) begin
                  k_in = 3'd0;
                  if (i_ff + 3'd1 == ranks_ff) begin
                     end_in   = 1'b0;
                     state_in = S_IDLE;
                  end else begin
                     i_in     = i_ff + 3'd1;
                     state_in = S_RNK;
                  end
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         letter_ff    <= '0;
         space_ff     <= '0;
         word_ff      <= '0;
         sent_ff      <= '0;
         match_ff     <= '0;
         plen_ff      <= 6'd0;
         distinct_ff  <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         k_ff         <= 3'd0;
         i_ff         <= 3'd0;
         ranks_ff     <= 3'd0;
      end else begin
         state_ff     <= state_in;
         letter_ff    <= letter_in;
         space_ff     <= space_in;
         word_ff      <= word_in;
         sent_ff      <= sent_in;
         match_ff     <= match_in;
         plen_ff      <= plen_in;
         distinct_ff  <= distinct_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         ranks_ff     <= ranks_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      best_ff      <= best_in;
      best_meta_ff <= best_meta_in;
      imeta_ff     <= imeta_in;
      match_ok_ff  <= match_ok_in;
      tmp_ff       <= tmp_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_q <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (chunk_we) begin
         chunk_mem[chunk_waddr] <= chunk_wdata;
      end
      chunk_q <= chunk_mem[chunk_raddr];
   end

endmodule

[hdl/text_word_statistics_core.sv]
// Top level of the text word statistics block: register port, front end and back end.
//
//  port group   direction  carries
//  req_*        in         one command with its text byte per request
//  rsp_*        out        summary, then eight-byte chunks of the top words
//  csr_*        in/out     target word bytes and target length
//
// A word end compares the word with the target chunk by chunk, then searches the
// stored entries one by one, reading chunks only for an entry of equal length
// (single table read port). End of text ranks by scanning the remaining entries
// once per rank and swapping the best one into place, then reads and sends each
// result chunk. Reset clears all control state; the table needs no clearing pass.
// A stalled result holds the back end when it has a further result to send, while
// the four-deep request queue keeps accepting until it is full.
`include "assert_macros.svh"
module text_word_statistics_core #(
   parameter int MAX_DISTINCT = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // text_byte[7:0]
   input  logic [1:0]    req_tuser,   // cmd[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // letter_total, space_total, word_total, sentence_total, match_total, rank,
   // frequency, text_chunk, chunk_index, word_length, zero pad to 200 bits
   output logic [199:0]  rsp_tdata,
   output logic          rsp_tuser,   // item_kind
   output logic          rsp_tlast,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [5:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   localparam logic [2:0] REG_TARGET_6   = 3'd6;
   localparam logic [2:0] REG_TARGET_LEN = 3'd7;

   logic [5:0][63:0] tgt_ff;
   logic [7:0] tgt6_ff;
   logic [5:0] tlen_ff;
   logic [6:0][63:0] target;
   logic [2:0] reg_idx;
   logic wr_en, op_valid, op_pop, rsp_valid;
   twsc_pkg::op_type op_head;
   twsc_pkg::rsp_type rsp;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign target     = {{56'd0, tgt6_ff}, tgt_ff};

   always_comb begin
      case (reg_idx)
         REG_TARGET_6:   csr_prdata = {56'd0, tgt6_ff};
         REG_TARGET_LEN: csr_prdata = {58'd0, tlen_ff};
         default:        csr_prdata = tgt_ff[reg_idx];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff  <= '0;
         tgt6_ff <= 8'd0;
         tlen_ff <= 6'd0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TARGET_6:   tgt6_ff <= csr_pwdata[7:0];
            REG_TARGET_LEN: tlen_ff <= csr_pwdata[5:0];
            default:        tgt_ff[reg_idx] <= csr_pwdata;
         endcase
      end
   end

   twsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_cmd  (req_tuser),
      .req_byte (req_tdata),
      .op_pop   (op_pop),
      .op_valid (op_valid),
      .op_head  (op_head)
   );

   twsc_back #(
      .MAX_DISTINCT(MAX_DISTINCT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_head   (op_head),
      .op_pop    (op_pop),
      .target    (target),
      .target_len(tlen_ff),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp.item_kind;
   assign rsp_tlast  = rsp.last;
   assign rsp_tdata  = {4'd0, rsp.word_length, rsp.chunk_index, rsp.text_chunk,
                        rsp.frequency, rsp.rank, rsp.match_total, rsp.sentence_total,
                        rsp.word_total, rsp.space_total, rsp.letter_total};

   `TWSC_ASSERT(a_summary_clean, rsp_tvalid && !rsp_tuser |-> rsp.frequency == '0 && rsp.rank == 3'd0 && rsp.text_chunk == 64'd0, "summary carries word fields")
   `TWSC_ASSERT(a_word_clean, rsp_tvalid && rsp_tuser |-> rsp.letter_total == '0 && rsp.word_length != 6'd0 && rsp.rank < 3'(twsc_pkg::TopCount), "bad word chunk fields")
   `TWSC_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

[sim/twsc_checker.sv]
// Checker for the text word statistics core: predicts results and compares them.
module twsc_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [199:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           error_count,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TableDepth = 1024;
   localparam int RegTargetByte48 = 6;
   localparam int RegTargetLength = 7;

   logic [63:0] target_word [7];
   logic [5:0]  target_len;

   logic [7:0]           word_buf [twsc_pkg::WordBytes];
   int                   buf_len;
   twsc_pkg::count_type  letters, spaces, words, marks, hits;
   logic [7:0]           dict_bytes [TableDepth][twsc_pkg::WordBytes];
   int                   dict_len [TableDepth];
   twsc_pkg::count_type  dict_count [TableDepth];
   int                   dict_used;

   twsc_pkg::rsp_type    expected_results [$];

   assign outstanding = expected_results.size();

   function automatic logic word_matches_target();
      logic [7:0] t;
      if (target_len == 0 || int'(target_len) != buf_len) return 1'b0;
      for (int k = 0; k < buf_len; k++) begin
         t = target_word[k >> 3][(k % 8) * 8 +: 8];
         if (t >= "A" && t <= "Z") t = t + 8'd32;
         if (t != word_buf[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic close_word();
      logic same;
      if (buf_len == 0) return;
      words = twsc_pkg::sat_inc(words);
      if (word_matches_target()) hits = twsc_pkg::sat_inc(hits);
      for (int j = 0; j < dict_used; j++) begin
         if (dict_len[j] == buf_len) begin
            same = 1'b1;
            for (int k = 0; k < buf_len; k++)
               if (dict_bytes[j][k] != word_buf[k]) same = 1'b0;
            if (same) begin
               dict_count[j] = twsc_pkg::sat_inc(dict_count[j]);
               buf_len = 0;
               return;
            end
         end
      end
      if (dict_used < TableDepth) begin
         for (int k = 0; k < twsc_pkg::WordBytes; k++)
            dict_bytes[dict_used][k] = word_buf[k];
         dict_len[dict_used] = buf_len;
         dict_count[dict_used] = twsc_pkg::count_type'(1);
         dict_used++;
      end
      buf_len = 0;
   endtask

   // Summary first, then rank by partial selection sort and emit word chunks.
   task automatic rank_and_emit();
      twsc_pkg::rsp_type r;
      int best, n_chunks, ranks;
      logic [7:0] tb;
      int tl;
      twsc_pkg::count_type tc;
      close_word();
      r = '0;
      r.item_kind = twsc_pkg::ITEM_SUMMARY;
      r.letter_total = letters;
      r.space_total = spaces;
      r.word_total = words;
      r.sentence_total = marks;
      r.match_total = hits;
      ranks = (dict_used < twsc_pkg::TopCount) ? dict_used : twsc_pkg::TopCount;
      r.last = (ranks == 0);
      expected_results.push_back(r);
      for (int i = 0; i < ranks; i++) begin
         best = i;
         for (int j = i + 1; j < dict_used; j++)
            if (dict_count[j] > dict_count[best]) best = j;
         if (best != i) begin
            for (int k = 0; k < twsc_pkg::WordBytes; k++) begin
               tb = dict_bytes[i][k];
               dict_bytes[i][k] = dict_bytes[best][k];
               dict_bytes[best][k] = tb;
            end
            tl = dict_len[i]; dict_len[i] = dict_len[best]; dict_len[best] = tl;
            tc = dict_count[i]; dict_count[i] = dict_count[best]; dict_count[best] = tc;
         end
         n_chunks = (dict_len[i] + 7) / 8;
         for (int k = 0; k < n_chunks; k++) begin
            r = '0;
            r.item_kind = twsc_pkg::ITEM_WORD;
            r.rank = 3'(i);
            r.frequency = dict_count[i];
            for (int b = 0; b < 8 && k * 8 + b < dict_len[i]; b++)
               r.text_chunk[b * 8 +: 8] = dict_bytes[i][k * 8 + b];
            r.chunk_index = 3'(k);
            r.word_length = 6'(dict_len[i]);
            r.last = (i == ranks - 1) && (k == n_chunks - 1);
            expected_results.push_back(r);
         end
      end
   endtask

   task automatic take_request(input logic [1:0] cmd, input logic [7:0] c);
      case (cmd)
         twsc_pkg::CMD_BEGIN: begin
            buf_len = 0;
            letters = '0; spaces = '0; words = '0; marks = '0; hits = '0;
            dict_used = 0;
         end
         twsc_pkg::CMD_TEXT: begin
            if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
               letters = twsc_pkg::sat_inc(letters);
               if (buf_len < twsc_pkg::WordBytes) begin
                  word_buf[buf_len] = (c <= "Z") ? c + 8'd32 : c;
                  buf_len++;
               end
            end else begin
               if ((c >= 8'd9 && c <= 8'd13) || c == " ") spaces = twsc_pkg::sat_inc(spaces);
               if (c == "." || c == "!" || c == "?") marks = twsc_pkg::sat_inc(marks);
               close_word();
            end
         end
         twsc_pkg::CMD_END: rank_and_emit();
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
         $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, e, a);
         error_count++;
      end
   endtask

   task automatic compare_result();
      twsc_pkg::rsp_type e;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result: actual %h kind %b last %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         error_count++;
         return;
      end
      e = expected_results.pop_front();
      check_field("item_kind", 64'(e.item_kind), 64'(rsp_tuser));
      check_field("letter_total", 64'(e.letter_total), 64'(rsp_tdata[19:0]));
      check_field("space_total", 64'(e.space_total), 64'(rsp_tdata[39:20]));
      check_field("word_total", 64'(e.word_total), 64'(rsp_tdata[59:40]));
      check_field("sentence_total", 64'(e.sentence_total), 64'(rsp_tdata[79:60]));
      check_field("match_total", 64'(e.match_total), 64'(rsp_tdata[99:80]));
      check_field("rank", 64'(e.rank), 64'(rsp_tdata[102:100]));
      check_field("frequency", 64'(e.frequency), 64'(rsp_tdata[122:103]));
      check_field("text_chunk", e.text_chunk, rsp_tdata[186:123]);
      check_field("chunk_index", 64'(e.chunk_index), 64'(rsp_tdata[189:187]));
      check_field("word_length", 64'(e.word_length), 64'(rsp_tdata[195:190]));
      check_field("pad", 64'd0, 64'(rsp_tdata[199:196]));
      check_field("last", 64'(e.last), 64'(rsp_tlast));
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) target_word[i] = '0;
         target_len = '0;
         buf_len = 0;
         letters = '0; spaces = '0; words = '0; marks = '0; hits = '0;
         dict_used = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[5:3] < RegTargetByte48)
               target_word[csr_paddr[5:3]] = csr_pwdata;
            else if (csr_paddr[5:3] == RegTargetByte48)
               target_word[RegTargetByte48] = {56'd0, csr_pwdata[7:0]};
            else if (csr_paddr[5:3] == RegTargetLength)
               target_len = csr_pwdata[5:0];
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
      end
   end

endmodule

[sim/tb_text_word_statistics_core.sv]
// Testbench top for the text word statistics core: clock, reset, stimulus and verdict.
module tb_text_word_statistics_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RegTargetLength = 7;
   localparam logic [1:0] CmdUnused = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic [1:0]   req_tuser = twsc_pkg::CMD_BEGIN;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [199:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [5:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   int   error_count;
   int   outstanding;
   logic calm = 1'b0;
   int   rsp_hold = 0;
   int   draw;
   int   sent_text = 0;

   string vocab [12] = '{"the", "a", "word", "words", "cat", "dog", "the", "zebra",
                         "quick", "brown", "it", "longerwordhere"};
   byte   separators [10] = '{8'd32, 8'd32, 8'd9, 8'd10, 8'd13, ".", "!", "?", ",", 8'd200};

   text_word_statistics_core i_dut (.*);

   twsc_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count, .outstanding
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Stall the result side for a drawn number of cycles after each result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = calm ? 0 : $urandom_range(0, 6);
         rsp_hold <= draw;
         rsp_tready <= (draw == 0);
      end else if (!rsp_tready) begin
         if (rsp_hold <= 1) rsp_tready <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [7:0] c);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= c;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (cmd == twsc_pkg::CMD_TEXT) sent_text++;
   endtask

   task automatic csr_write(input int index, input logic [63:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 6'(index * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_target(input logic [63:0] chars [7], input logic [5:0] len);
      for (int i = 0; i < 7; i++) csr_write(i, chars[i]);
      csr_write(RegTargetLength, {58'd0, len});
   endtask

   // Drain all results, then let the block settle before touching registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(twsc_pkg::CMD_TEXT, s[i]);
   endtask

   task automatic send_word(input string w);
      byte c;
      for (int i = 0; i < w.len(); i++) begin
         c = w[i];
         if ($urandom_range(0, 3) == 0) c = c - 8'd32;
         send_request(twsc_pkg::CMD_TEXT, c);
      end
   endtask

   task automatic random_document();
      int n_words;
      n_words = $urandom_range(3, 15);
      if ($urandom_range(0, 9) != 0) send_request(twsc_pkg::CMD_BEGIN, 8'($urandom));
      for (int w = 0; w < n_words; w++) begin
         send_word(vocab[$urandom_range(0, 11)]);
         case ($urandom_range(0, 11))
            0: send_request(twsc_pkg::CMD_TEXT, 8'($urandom));
            1: send_request(CmdUnused, 8'($urandom));
            2: ;
            default: send_request(twsc_pkg::CMD_TEXT, separators[$urandom_range(0, 9)]);
         endcase
      end
      send_request(twsc_pkg::CMD_END, 8'($urandom));
   endtask

   initial begin
      logic [63:0] chars [7];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Target "THE", lower-cased by the block before the compare.
      chars = '{64'h0000_0000_0045_4854, 0, 0, 0, 0, 0, 0};
      set_target(chars, 6'd3);
      calm = 1'b1;
      send_request(twsc_pkg::CMD_BEGIN, 8'h00);
      send_text("THE the");
      send_text("!?.");
      send_request(twsc_pkg::CMD_TEXT, 8'd9);
      send_request(twsc_pkg::CMD_TEXT, 8'd13);
      send_request(twsc_pkg::CMD_TEXT, 8'hff);
      send_text("Zz@Aa[`{tHe ");
      send_request(CmdUnused, 8'hff);
      send_request(twsc_pkg::CMD_END, 8'h00);
      wait_idle();
      calm = 1'b0;

      // Overlong word truncated to 49 bytes and matched by a 49-byte target.
      chars = '{64'h5858_5858_7878_7878, 64'h7878_7878_5858_5858, 64'h5858_7878_5858_7878,
                64'h7878_7878_7878_7878, 64'h5858_5858_5858_5858, 64'h7878_5858_7878_5858,
                64'h58};
      set_target(chars, 6'd49);
      send_request(twsc_pkg::CMD_BEGIN, 8'h00);
      for (int i = 0; i < 55; i++)
         send_request(twsc_pkg::CMD_TEXT, (i % 3 == 0) ? "X" : "x");
      send_request(twsc_pkg::CMD_TEXT, " ");
      for (int i = 0; i < 49; i++) send_request(twsc_pkg::CMD_TEXT, "x");
      send_request(twsc_pkg::CMD_END, 8'h00);
      // Text after the end keeps accumulating into the next summary.
      send_text("x dog x ");
      send_request(twsc_pkg::CMD_END, 8'h00);
      wait_idle();

      // All ones, zero length: nothing matches.
      chars = '{'1, '1, '1, '1, '1, '1, 64'hff};
      set_target(chars, 6'd0);
      while (sent_text < 180) begin
         calm = ($urandom_range(0, 3) == 0);
         random_document();
      end
      wait_idle();

      chars = '{64'h0000_0000_6472_6f77, 64'($urandom), 64'($urandom), 0, 0, 0, 64'($urandom)};
      set_target(chars, 6'd4);
      while (sent_text < 240) begin
         calm = ($urandom_range(0, 3) == 0);
         random_document();
      end
      wait_idle();

      chars = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom)};
      set_target(chars, 6'($urandom_range(1, 49)));
      random_document();
      wait_idle();
      repeat (200) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
